[src/assert_macros.svh]
// assertion macros for the relay destination table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[src/urdt_pkg.sv]
// package: types, constants and codes for the relay destination table
`default_nettype none
package urdt_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotW = 6;
  localparam int unsigned KeyBytes = 16;
  localparam logic [15:0] NegcacheReset = 16'd2000;

  typedef enum logic [1:0] {
    REQ_DATAGRAM = 2'd0, REQ_OPEN = 2'd1, REQ_ERROR = 2'd2, REQ_TEARDOWN = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0, ACT_SEND = 2'd1, ACT_OPEN = 2'd2, ACT_CLOSE = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    WHY_NONE = 3'd0, WHY_SOURCE = 3'd1, WHY_HEADER = 3'd2, WHY_NEGCACHE = 3'd3,
    WHY_FULL = 3'd4, WHY_HOSTLEN = 3'd5
  } why_e;

  typedef enum logic [1:0] {
    ADDR_PEER_IP = 2'd0, ADDR_NEGCACHE = 2'd1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_DECIDE, ST_FREE, ST_TEAR, ST_TEAR_END
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic        hdr_ok;
    logic [7:0]  addr_type;
    logic [63:0] host_high;
    logic [63:0] host_low;
    logic [4:0]  host_bytes;
    logic [15:0] dst_port;
    logic [5:0]  slot;
    logic        flag;
    logic [63:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] slot_out;
    logic [2:0] drop_reason;
    logic       last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic   load;       // capture request, run source filter
    logic   match_all;  // compare all entries, latch first hit
    logic   decide;     // apply lookup outcome
    logic   event_do;   // open result or error
    logic   tear_step;  // step over one entry of teardown
    logic   tear_clear; // clear all flags
    logic   emit;       // drive result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       early_done; // result settled at load
    logic       tear_hit;   // current teardown entry live
    logic       tear_final; // no live entry beyond the current one
    logic       tear_end;   // at last entry
    logic       any_live;
  } sts_t;

  function automatic logic [63:0] byte_mask(input logic [4:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (5'(b) < n) m[63 - 8*b -: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

[src/urdt_ctrl.sv]
// controller: sequences one request through lookup, decision, session events and teardown
`default_nettype none
module urdt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  urdt_pkg::req_e  req_i,
  input  urdt_pkg::sts_t  sts_i,
  output urdt_pkg::ctl_t  ctl_o,
  output logic            busy_o,
  output logic            last_o
);
  import urdt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    last_o = 1'b1;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          unique case (req_i)
            REQ_DATAGRAM: state_d = ST_SEARCH;
            REQ_OPEN, REQ_ERROR: state_d = ST_FREE;
            REQ_TEARDOWN: state_d = ST_TEAR;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (sts_i.early_done) begin
          ctl_o.emit = 1'b1;
          state_d = ST_IDLE;
        end else begin
          ctl_o.match_all = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ctl_o.decide = 1'b1;
        ctl_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FREE: begin
        ctl_o.event_do = 1'b1;
        ctl_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TEAR: begin
        ctl_o.tear_step = 1'b1;
        if (sts_i.tear_hit) begin
          ctl_o.emit = 1'b1;
          last_o = sts_i.tear_final;
        end
        if (sts_i.tear_end) state_d = ST_TEAR_END;
      end
      ST_TEAR_END: begin
        // the plain closing word only when nothing was closed
        ctl_o.tear_clear = 1'b1;
        ctl_o.emit = !sts_i.any_live;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[src/urdt_datapath.sv]
// datapath: source lock, entry table, key compare and result forming
`default_nettype none
module urdt_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  urdt_pkg::req_t  req_i,
  input  urdt_pkg::ctl_t  ctl_i,
  input  logic            last_i,
  input  logic [31:0]     peer_ip_i,
  input  logic [15:0]     window_i,
  output urdt_pkg::sts_t  sts_o,
  output logic            done_o,
  output urdt_pkg::res_t  res_o
);
  import urdt_pkg::*;

  logic [TableEntries-1:0] used_q, live_q, dead_q;
  logic [TableEntries-1:0] used_d, live_d, dead_d;
  logic [7:0]   type_q [TableEntries];
  logic [127:0] host_q [TableEntries];
  logic [4:0]   hlen_q [TableEntries];
  logic [15:0]  port_q [TableEntries];
  logic [63:0]  ftime_q [TableEntries];

  logic locked_q;
  logic [31:0] cip_q;
  logic [15:0] cport_q;

  req_t r_q;
  logic [127:0] key_q;
  logic early_q;
  logic [2:0] early_why_q;

  logic hit_q;
  logic [SlotW-1:0] hit_idx_q, tidx_q;
  logic [63:0] ft_hit_q;

  res_t out_q, res_d;
  logic done_q;

  // source filter and masked key, from the raw request
  logic src_bad;
  logic [2:0] why_d;
  logic [127:0] key_d;
  always_comb begin
    src_bad = locked_q ? (req_i.src_ip != cip_q || req_i.src_port != cport_q)
                       : (req_i.src_ip != peer_ip_i);
    if (src_bad) why_d = WHY_SOURCE;
    else if (!req_i.hdr_ok) why_d = WHY_HEADER;
    else if (req_i.host_bytes > 5'(KeyBytes)) why_d = WHY_HOSTLEN;
    else why_d = WHY_NONE;
    key_d = {req_i.host_high & byte_mask(req_i.host_bytes),
             req_i.host_low & byte_mask((req_i.host_bytes > 5'd8) ?
                                        req_i.host_bytes - 5'd8 : 5'd0)};
  end

  // parallel key compare over all entries
  logic [TableEntries-1:0] cmp;
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      cmp[i] = used_q[i] && type_q[i] == r_q.addr_type && hlen_q[i] == r_q.host_bytes &&
               port_q[i] == r_q.dst_port && host_q[i] == key_q;
    end
  end

  // first hit, as a priority encoder
  logic hit_d;
  logic [SlotW-1:0] hidx_d;
  always_comb begin
    hit_d = 1'b0; hidx_d = '0;
    for (int i = TableEntries-1; i >= 0; i--) begin
      if (cmp[i]) begin hit_d = 1'b1; hidx_d = SlotW'(i); end
    end
  end

  // free slot once the hit entry is retired
  logic [TableEntries-1:0] used_after;
  logic free2;
  logic [SlotW-1:0] fidx2;
  always_comb begin
    used_after = used_q;
    if (hit_q) used_after[hit_idx_q] = 1'b0;
    free2 = 1'b0; fidx2 = '0;
    for (int i = TableEntries-1; i >= 0; i--) begin
      if (!used_after[i]) begin free2 = 1'b1; fidx2 = SlotW'(i); end
    end
  end

  // negative cache test on the latched hit
  logic [63:0] age;
  logic in_window;
  assign age = r_q.now_ms - ft_hit_q;
  assign in_window = (ft_hit_q != 64'd0) && (age < {48'd0, window_i});

  // lookup outcome and session event checks
  logic keep_hit, open_ok, err_ok;
  assign keep_hit = hit_q && ((dead_q[hit_idx_q] && in_window) ||
                              (!dead_q[hit_idx_q] && live_q[hit_idx_q]));
  assign open_ok = used_q[r_q.slot] && !live_q[r_q.slot] && !dead_q[r_q.slot];
  assign err_ok = used_q[r_q.slot] && live_q[r_q.slot] && !dead_q[r_q.slot];

  // live entries and teardown status
  logic [TableEntries-1:0] live_vec;
  logic more_live;
  assign live_vec = used_q & live_q & ~dead_q;
  always_comb begin
    more_live = 1'b0;
    for (int i = 0; i < TableEntries; i++) begin
      if (SlotW'(i) > tidx_q && live_vec[i]) more_live = 1'b1;
    end
  end
  assign sts_o.early_done = early_q;
  assign sts_o.tear_hit = live_vec[tidx_q];
  assign sts_o.tear_final = !more_live;
  assign sts_o.tear_end = (tidx_q == SlotW'(TableEntries-1));
  assign sts_o.any_live = |live_vec;

  // next entry flags
  always_comb begin
    used_d = used_q; live_d = live_q; dead_d = dead_q;
    if (ctl_i.decide && !keep_hit) begin
      if (hit_q) begin
        used_d[hit_idx_q] = 1'b0; live_d[hit_idx_q] = 1'b0; dead_d[hit_idx_q] = 1'b0;
      end
      if (free2) begin
        used_d[fidx2] = 1'b1; live_d[fidx2] = 1'b0; dead_d[fidx2] = 1'b0;
      end
    end
    if (ctl_i.event_do) begin
      if (r_q.req_type == REQ_OPEN) begin
        if (open_ok) begin
          if (r_q.flag) live_d[r_q.slot] = 1'b1;
          else used_d[r_q.slot] = 1'b0;
        end
      end else if (err_ok) begin
        dead_d[r_q.slot] = 1'b1; live_d[r_q.slot] = 1'b0;
      end
    end
    if (ctl_i.tear_clear) begin
      used_d = '0; live_d = '0; dead_d = '0;
    end
  end

  // result word
  always_comb begin
    res_d = '0;
    res_d.last = last_i;
    if (ctl_i.emit) begin
      if (early_q && r_q.req_type == REQ_DATAGRAM) begin
        res_d.drop_reason = early_why_q;
      end else if (ctl_i.decide) begin
        if (hit_q && dead_q[hit_idx_q] && in_window) res_d.drop_reason = WHY_NEGCACHE;
        else if (hit_q && !dead_q[hit_idx_q] && live_q[hit_idx_q]) begin
          res_d.action = ACT_SEND; res_d.slot_out = hit_idx_q;
        end else if (free2) begin
          res_d.action = ACT_OPEN; res_d.slot_out = fidx2;
        end else res_d.drop_reason = WHY_FULL;
      end else if (ctl_i.event_do) begin
        if (r_q.req_type == REQ_OPEN && r_q.flag && open_ok) begin
          res_d.action = ACT_SEND; res_d.slot_out = r_q.slot;
        end
      end else if (ctl_i.tear_step) begin
        res_d.action = ACT_CLOSE; res_d.slot_out = tidx_q;
      end
    end
  end

  // control registers: lock, flags, capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0; cip_q <= '0; cport_q <= '0;
      used_q <= '0; live_q <= '0; dead_q <= '0;
      early_q <= 1'b0; early_why_q <= WHY_NONE;
      hit_q <= 1'b0; tidx_q <= '0; done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.emit;
      used_q <= used_d; live_q <= live_d; dead_q <= dead_d;
      if (ctl_i.load) begin
        early_q <= (why_d != WHY_NONE);
        early_why_q <= why_d;
        if (req_i.req_type == REQ_DATAGRAM && !locked_q && !src_bad) begin
          locked_q <= 1'b1; cip_q <= req_i.src_ip; cport_q <= req_i.src_port;
        end
      end
      if (ctl_i.match_all) hit_q <= hit_d;
      if (ctl_i.load) tidx_q <= '0;
      else if (ctl_i.tear_step) tidx_q <= tidx_q + SlotW'(1);
    end
  end

  // payload registers: request, key, table contents, result
  always_ff @(posedge clk_i) begin
    out_q <= res_d;
    if (ctl_i.load) begin
      r_q <= req_i; key_q <= key_d;
    end
    if (ctl_i.match_all) begin
      hit_idx_q <= hidx_d;
      ft_hit_q <= ftime_q[hidx_d];
    end
    if (ctl_i.decide && !keep_hit && free2) begin
      type_q[fidx2] <= r_q.addr_type; host_q[fidx2] <= key_q;
      hlen_q[fidx2] <= r_q.host_bytes; port_q[fidx2] <= r_q.dst_port;
      ftime_q[fidx2] <= '0;
    end
    if (ctl_i.event_do) begin
      if (r_q.req_type == REQ_OPEN) begin
        if (open_ok) ftime_q[r_q.slot] <= '0;
      end else if (err_ok && !r_q.flag) begin
        ftime_q[r_q.slot] <= r_q.now_ms;
      end
    end
  end

  assign res_o = out_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

[src/udp_relay_destination_table_unit.sv]
// top level: configuration registers, controller and datapath
// One request is taken at an edge where start is high and busy is low. A
// datagram dropped by the source, header or length checks, an open result and
// a session error each have their word formed in the state entered when the
// request is taken (search or free) and registered out; a table lookup passes
// a search state (parallel key compare, first hit latched) and a decide state
// (first-free search and decision) before its word is registered out. The
// next request can be taken at the edge that takes the word. Teardown walks
// all 64 slots, one per cycle, with a close word for each live slot; the
// final close carries last, and with no live slot a single plain word comes
// from a closing state after the walk. Results are shown for one cycle under
// done_o; the receiver cannot stall them.
`default_nettype none
`include "assert_macros.svh"
module udp_relay_destination_table_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  urdt_pkg::req_t  req_i,
  output logic            done_o,
  output urdt_pkg::res_t  res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import urdt_pkg::*;

  logic [31:0] peer_ip_q;
  logic [15:0] window_q;
  ctl_t ctl;
  sts_t sts;
  logic last;
  logic wr;
  reg_e cfg_sel;

  // configuration registers
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg_sel = reg_e'({1'b0, paddr[2]});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_ip_q <= '0; window_q <= NegcacheReset;
    end else if (wr) begin
      if (cfg_sel == ADDR_NEGCACHE) window_q <= pwdata[15:0];
      else peer_ip_q <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (cfg_sel == ADDR_NEGCACHE) prdata = {16'd0, window_q};
    else prdata = peer_ip_q;
  end

  urdt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .req_i(req_e'(req_i.req_type)),
    .sts_i(sts), .ctl_o(ctl), .busy_o(busy), .last_o(last)
  );

  urdt_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .ctl_i(ctl), .last_i(last),
    .peer_ip_i(peer_ip_q), .window_i(window_q), .sts_o(sts),
    .done_o, .res_o
  );

  // checks
  `ASSERT_NEVER(a_no_start_busy_load, clk_i, rst_ni, ctl.load && busy)
  `ASSERT_IMPL(a_load_busy, clk_i, rst_ni, ctl.load |=> busy)
  `ASSERT_NEVER(a_send_reason, clk_i, rst_ni,
                done_o && res_o.action != ACT_NONE && res_o.drop_reason != WHY_NONE)
endmodule
`default_nettype wire

[verif/udp_relay_destination_table_unit_tb.sv]
// testbench for the relay destination table: directed and random words checked against a predictor
`timescale 1ns / 1ps
module udp_relay_destination_table_unit_tb;
  import urdt_pkg::*;

  localparam int NSLOT = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  res_t        res_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  udp_relay_destination_table_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .res_o(res_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0]  cfg_peer_ip;
  logic [15:0]  cfg_window;
  logic         locked;
  logic [31:0]  lock_ip;
  logic [15:0]  lock_port;
  logic         ent_used [NSLOT];
  logic         ent_live [NSLOT];
  logic         ent_dead [NSLOT];
  logic [7:0]   ent_type [NSLOT];
  logic [127:0] ent_host [NSLOT];
  logic [4:0]   ent_len  [NSLOT];
  logic [15:0]  ent_port [NSLOT];
  logic [63:0]  ent_fail [NSLOT];

  res_t expected_words[$];
  int   errors = 0;
  int   words_seen = 0;
  int   items_sent = 0;
  bit   idle_on = 1'b1;

  function automatic logic [63:0] keep_bytes(input int n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) if (b < n) m[63-8*b -: 8] = 8'hff;
    return m;
  endfunction

  function automatic res_t mk(input act_e a, input int s, input why_e w, input int l);
    res_t r;
    r.action = a; r.slot_out = s[5:0]; r.drop_reason = w; r.last = l[0];
    return r;
  endfunction

  function automatic void free_entry(input int i);
    ent_used[i] = 1'b0; ent_live[i] = 1'b0; ent_dead[i] = 1'b0; ent_fail[i] = '0;
  endfunction

  // work out the result words of one request
  function automatic void predict_table(input req_t q);
    logic [63:0] hh, hl;
    int found, n;
    found = -1;
    n = 0;
    case (req_e'(q.req_type))
      REQ_DATAGRAM: begin
        if (!locked) begin
          if (q.src_ip != cfg_peer_ip) begin
            expected_words.push_back(mk(ACT_NONE, 0, WHY_SOURCE, 1)); return;
          end
          locked = 1'b1; lock_ip = q.src_ip; lock_port = q.src_port;
        end else if (q.src_ip != lock_ip || q.src_port != lock_port) begin
          expected_words.push_back(mk(ACT_NONE, 0, WHY_SOURCE, 1)); return;
        end
        if (!q.hdr_ok) begin expected_words.push_back(mk(ACT_NONE, 0, WHY_HEADER, 1)); return; end
        if (q.host_bytes > 16) begin
          expected_words.push_back(mk(ACT_NONE, 0, WHY_HOSTLEN, 1)); return;
        end
        hh = q.host_high & keep_bytes(q.host_bytes);
        hl = q.host_low & keep_bytes(q.host_bytes > 8 ? q.host_bytes - 8 : 0);
        for (int i = 0; i < NSLOT; i++)
          if (found < 0 && ent_used[i] && ent_type[i] == q.addr_type
              && ent_len[i] == q.host_bytes
              && ent_port[i] == q.dst_port && ent_host[i] == {hh, hl}) found = i;
        if (found >= 0) begin
          if (ent_dead[found]) begin
            if (ent_fail[found] != 0 && (q.now_ms - ent_fail[found]) < {48'd0, cfg_window}) begin
              expected_words.push_back(mk(ACT_NONE, 0, WHY_NEGCACHE, 1)); return;
            end
            free_entry(found);
          end else if (ent_live[found]) begin
            expected_words.push_back(mk(ACT_SEND, found, WHY_NONE, 1)); return;
          end else free_entry(found);
        end
        for (int i = 0; i < NSLOT; i++)
          if (!ent_used[i]) begin
            free_entry(i);
            ent_used[i] = 1'b1; ent_type[i] = q.addr_type; ent_host[i] = {hh, hl};
            ent_len[i] = q.host_bytes; ent_port[i] = q.dst_port;
            expected_words.push_back(mk(ACT_OPEN, i, WHY_NONE, 1)); return;
          end
        expected_words.push_back(mk(ACT_NONE, 0, WHY_FULL, 1));
      end
      REQ_OPEN: begin
        if (ent_used[q.slot] && !ent_live[q.slot] && !ent_dead[q.slot]) begin
          if (q.flag) begin
            ent_live[q.slot] = 1'b1; ent_fail[q.slot] = '0;
            expected_words.push_back(mk(ACT_SEND, q.slot, WHY_NONE, 1)); return;
          end
          free_entry(q.slot);
        end
        expected_words.push_back(mk(ACT_NONE, 0, WHY_NONE, 1));
      end
      REQ_ERROR: begin
        if (ent_used[q.slot] && ent_live[q.slot] && !ent_dead[q.slot]) begin
          if (!q.flag) ent_fail[q.slot] = q.now_ms;
          ent_dead[q.slot] = 1'b1; ent_live[q.slot] = 1'b0;
        end
        expected_words.push_back(mk(ACT_NONE, 0, WHY_NONE, 1));
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (ent_used[i] && !ent_dead[i] && ent_live[i]) begin
            expected_words.push_back(mk(ACT_CLOSE, i, WHY_NONE, 0)); n++;
          end
          ent_used[i] = 1'b0; ent_live[i] = 1'b0; ent_dead[i] = 1'b0;
        end
        if (n == 0) expected_words.push_back(mk(ACT_NONE, 0, WHY_NONE, 1));
        else expected_words[$].last = 1'b1;
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && done_o) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, res_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (res_o.action !== e.action || res_o.slot_out !== e.slot_out ||
            res_o.drop_reason !== e.drop_reason || res_o.last !== e.last) begin
          $display("%0t: mismatch expected act %0d slot %0d why %0d last %0d, actual %0d %0d %0d %0d",
                   $time, e.action, e.slot_out, e.drop_reason, e.last,
                   res_o.action, res_o.slot_out, res_o.drop_reason, res_o.last);
          errors++;
        end
      end
    end
  end

  task automatic gap();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  // send one request word
  task automatic send_req(input req_t q);
    gap();
    while (busy) @(negedge clk_i);
    start <= 1'b1;
    req_i <= q;
    @(negedge clk_i);
    start <= 1'b0;
    predict_table(q);
    items_sent++;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {r[0], 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (r == ADDR_PEER_IP) cfg_peer_ip = v; else cfg_window = v[15:0];
  endtask

  function automatic req_t base_req(input req_e t);
    req_t q;
    q = '0;
    q.req_type = t; q.src_ip = lock_ip; q.src_port = lock_port; q.hdr_ok = 1'b1;
    return q;
  endfunction

  function automatic req_t dgram(input int k, input logic [63:0] now);
    req_t q;
    q = base_req(REQ_DATAGRAM);
    q.addr_type = k[7:0]; q.host_bytes = 5'd4; q.host_high = {k[31:0], 32'h0};
    q.dst_port = 16'd53; q.now_ms = now;
    return q;
  endfunction

  function automatic req_t evt(input req_e t, input int s, input logic f, input logic [63:0] now);
    req_t q;
    q = base_req(t);
    q.slot = s[5:0]; q.flag = f; q.now_ms = now;
    return q;
  endfunction

  // source lock, header and length drops, extremes of the fields
  task automatic test_filters();
    req_t q;
    write_reg(ADDR_PEER_IP, 32'hc0a8_0001);
    q = '0; q.src_ip = 32'h0a00_0001; q.hdr_ok = 1'b1;
    send_req(q);
    q.src_ip = 32'hc0a8_0001; q.src_port = 16'hffff; q.hdr_ok = 1'b0;
    send_req(q);
    send_req(dgram(1, 0));
    q = dgram(2, 0); q.src_port = 16'h1234; send_req(q);
    q = dgram(2, 0); q.src_ip = ~q.src_ip; send_req(q);
    q = dgram(3, 0); q.host_bytes = 5'd17; send_req(q);
    q = dgram(3, 0); q.host_bytes = 5'd31; send_req(q);
    q = dgram(4, 0); q.host_bytes = 5'd16; q.host_high = '1; q.host_low = '1;
    q.addr_type = 8'hff; q.dst_port = 16'hffff; q.now_ms = '1; send_req(q);
    q.host_low = 64'h0; send_req(q);
    q = dgram(5, 0); q.host_bytes = 5'd0; q.host_high = {$urandom, $urandom}; send_req(q);
    q.host_high = ~q.host_high; send_req(q);
  endtask

  // open results, errors, negative cache, clock going back, stray events
  task automatic test_sessions();
    send_req(evt(REQ_OPEN, 1, 1'b1, 0));
    send_req(dgram(1, 0));
    send_req(evt(REQ_OPEN, 1, 1'b1, 0));
    send_req(evt(REQ_OPEN, 63, 1'b1, 0));
    send_req(evt(REQ_ERROR, 1, 1'b0, 64'd5000));
    send_req(dgram(1, 64'd5100));
    send_req(dgram(1, 64'd4000));
    send_req(evt(REQ_ERROR, 2, 1'b0, 0));
    send_req(evt(REQ_OPEN, 0, 1'b0, 0));
    send_req(dgram(9, 0));
    send_req(dgram(9, 0));
    send_req(evt(REQ_OPEN, 0, 1'b1, 0));
    send_req(evt(REQ_ERROR, 0, 1'b0, 0));
    send_req(dgram(9, 1));
    send_req(evt(REQ_TEARDOWN, 0, 1'b0, 0));
    send_req(evt(REQ_TEARDOWN, 0, 1'b0, 0));
  endtask

  // fill all slots, table full, teardown of several live sessions
  task automatic test_full_table();
    for (int i = 0; i < NSLOT; i++) send_req(dgram(100 + i, 0));
    send_req(dgram(300, 0));
    for (int i = 0; i < NSLOT; i += 8) send_req(evt(REQ_OPEN, i, 1'b1, 0));
    send_req(evt(REQ_TEARDOWN, 0, 1'b0, 0));
  endtask

  // random sequences over a small key set
  task automatic test_random(input int count);
    req_t q;
    int r;
    logic [287:0] raw;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      q = dgram($urandom_range(0, 7), {32'h0, $urandom_range(0, 6000)});
      if (r < 45) begin
        if ($urandom_range(0, 3) == 0) q.host_bytes = 5'($urandom_range(0, 16));
      end else if (r < 65) q = evt(REQ_OPEN, $urandom_range(0, 9), $urandom_range(0, 3) != 0, 0);
      else if (r < 80) q = evt(REQ_ERROR, $urandom_range(0, 9), 1'($urandom), q.now_ms);
      else if (r < 84) q = evt(REQ_TEARDOWN, $urandom_range(0, 63), 1'($urandom), 0);
      else begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        q = raw[$bits(req_t)-1:0];
        q.req_type = REQ_DATAGRAM;
        if ($urandom_range(0, 1)) begin q.src_ip = lock_ip; q.src_port = lock_port; end
      end
      send_req(q);
    end
  endtask

  initial begin
    cfg_peer_ip = '0; cfg_window = 16'd2000; locked = 1'b0; lock_ip = '0; lock_port = '0;
    for (int i = 0; i < NSLOT; i++) begin
      free_entry(i); ent_type[i] = '0; ent_host[i] = '0; ent_len[i] = '0; ent_port[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_reg(ADDR_NEGCACHE, 32'd1000);
    test_filters();
    test_sessions();
    drain();
    write_reg(ADDR_NEGCACHE, 32'd0);
    test_full_table();
    drain();
    write_reg(ADDR_NEGCACHE, 32'hffff);
    test_random(10);
    drain();
    write_reg(ADDR_NEGCACHE, 32'd2000);
    test_random(6);
    idle_on = 1'b0;
    test_random(4);
    drain();
    $display("covered %0d requests and %0d result words: source lock, drops, negative cache,",
             items_sent, words_seen);
    $display("open and error events, a full table, teardowns and random traffic");
    if (errors == 0 && expected_words.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

[udp_relay_destination_table_unit.f]
+incdir+src
src/urdt_pkg.sv
src/urdt_ctrl.sv
src/urdt_datapath.sv
src/udp_relay_destination_table_unit.sv
verif/udp_relay_destination_table_unit_tb.sv
